// ===== sv/hfd_pkg.sv =====
// hfd_pkg: shared types, constants and helpers for the header/footer byte deframer
// depends on nothing; used by hfd_sync and header_footer_byte_deframer
package hfd_pkg;

	// frame format
	localparam int HEADER_BYTES    = 5;
	localparam int FOOTER_BYTES    = 2;
	localparam int MAX_FRAME_BYTES = 256;

	// register widths and reset values
	localparam int HDR_W       = 40;
	localparam int FTR_W       = 16;
	localparam int HDR_STORED  = HDR_W / 8;
	localparam int CFG_W       = HDR_W;
	localparam logic [HDR_W-1:0] HDR_RESET = 40'h6A736F6E3A; // "json:"
	localparam logic [FTR_W-1:0] FTR_RESET = 16'h0D0A;       // CR LF

	// register indexes
	localparam logic CFG_HEADER = 1'b0;
	localparam logic CFG_FOOTER = 1'b1;

	// sync state
	typedef enum logic [1:0] {
		MODE_HUNT   = 2'd0,
		MODE_BODY   = 2'd1,
		MODE_VERIFY = 2'd2
	} mode_t;

	// one result from the sync logic to the output register
	typedef struct packed {
		logic       has_result;
		logic [7:0] data_byte;
		logic       first_of_frame;
		logic       end_of_frame;
		logic       abort_frame;
		logic [7:0] frame_length;
	} hfd_result_t;

	// header byte at match position idx, first byte most significant;
	// positions above the stored register read as zero
	function automatic logic [7:0] hdr_byte(input logic [HDR_W-1:0] pat,
						input logic [2:0] idx);
		logic [7:0] r;
		r = '0;
		for (int k = 0; k < HDR_STORED; k++) begin
			if (int'(idx) == HEADER_BYTES - 1 - k)
				r = pat[8*k +: 8];
		end
		return r;
	endfunction

	// footer byte at match position idx, first byte in the high byte
	function automatic logic [7:0] ftr_byte(input logic [FTR_W-1:0] pat,
						input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0:    r = pat[15:8];
			3'd1:    r = pat[7:0];
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/hfd_in_if.sv =====
// hfd_in_if: valid/ready channel carrying one received byte per item
// depends on nothing
interface hfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== sv/hfd_out_if.sv =====
// hfd_out_if: valid/ready channel carrying one deframed body byte per item
// depends on nothing
interface hfd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_of_frame;
	logic       end_of_frame;
	logic       abort_frame;
	logic [7:0] frame_length;

	modport source (output valid, output data_byte, output first_of_frame,
			output end_of_frame, output abort_frame, output frame_length,
			input ready);
	modport sink   (input valid, input data_byte, input first_of_frame,
			input end_of_frame, input abort_frame, input frame_length,
			output ready);
endinterface

// ===== sv/hfd_sync.sv =====
// hfd_sync: header hunt, footer watch and frame length count for one byte per step
// depends on hfd_pkg
module hfd_sync (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic [7:0]                byte_s1,
	input  logic [hfd_pkg::HDR_W-1:0] header_q,
	input  logic [hfd_pkg::FTR_W-1:0] footer_q,
	output hfd_pkg::hfd_result_t      res
);
	import hfd_pkg::*;

	mode_t      mode_q, mode_d;
	logic [2:0] idx_q, idx_d;
	logic [8:0] cnt_q, cnt_d;

	logic [2:0] idx_inc;
	logic [8:0] cnt_inc;
	logic       hdr_hit, hdr_done;
	logic       ftr_hit, ftr_done, ftr_first, limit_hit;

	// compares against the pattern bytes and the length limit
	assign idx_inc   = idx_q + 3'd1;
	assign cnt_inc   = cnt_q + 9'd1;
	assign hdr_hit   = (hdr_byte(header_q, idx_q) == byte_s1);
	assign hdr_done  = ({1'b0, idx_inc} >= 4'(HEADER_BYTES)) || (idx_inc == 3'd0);
	assign ftr_hit   = (ftr_byte(footer_q, idx_q) == byte_s1);
	assign ftr_done  = ({1'b0, idx_inc} >= 4'(FOOTER_BYTES));
	assign ftr_first = (ftr_byte(footer_q, 3'd0) == byte_s1);
	assign limit_hit = (cnt_inc >= 9'(MAX_FRAME_BYTES));

	// next state
	always_comb begin
		mode_d = mode_q;
		idx_d  = idx_q;
		cnt_d  = cnt_q;
		case (mode_q)
			MODE_BODY, MODE_VERIFY: begin
				cnt_d = cnt_inc;
				if (limit_hit) begin
					mode_d = MODE_HUNT;
					idx_d  = 3'd0;
					cnt_d  = 9'd0;
				end else if (mode_q == MODE_BODY) begin
					if (ftr_hit) begin
						idx_d  = idx_inc;
						mode_d = MODE_VERIFY;
					end
				end else if (ftr_hit) begin
					idx_d = idx_inc;
					if (ftr_done) begin
						mode_d = MODE_HUNT;
						idx_d  = 3'd0;
						cnt_d  = 9'd0;
					end
				end else if (ftr_first) begin
					// broken footer that restarts the footer
					mode_d = MODE_VERIFY;
					idx_d  = 3'd1;
				end else begin
					mode_d = MODE_BODY;
					idx_d  = 3'd0;
				end
			end
			default: begin
				// hunting; a mismatch is not rechecked as a first header byte
				if (hdr_hit) begin
					idx_d = idx_inc;
					if (hdr_done) begin
						mode_d = MODE_BODY;
						idx_d  = 3'd0;
						cnt_d  = 9'd0;
					end
				end else begin
					idx_d = 3'd0;
				end
			end
		endcase
	end

	// result fields
	always_comb begin
		res                = '0;
		res.data_byte      = byte_s1;
		res.first_of_frame = (cnt_q == 9'd0);
		case (mode_q)
			MODE_BODY: begin
				res.has_result  = 1'b1;
				res.abort_frame = limit_hit;
			end
			MODE_VERIFY: begin
				res.has_result   = 1'b1;
				res.abort_frame  = limit_hit;
				res.end_of_frame = !limit_hit && ftr_hit && ftr_done;
				if (!limit_hit && ftr_hit && ftr_done)
					res.frame_length = cnt_inc[7:0];
			end
			default: begin
				res.has_result = 1'b0;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HUNT;
			idx_q  <= 3'd0;
			cnt_q  <= 9'd0;
		end else if (step) begin
			mode_q <= mode_d;
			idx_q  <= idx_d;
			cnt_q  <= cnt_d;
		end
	end

	// state consistency
	a_hunt_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_HUNT |-> cnt_q == 9'd0)
		else $error("body count nonzero while hunting");
	a_body_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_BODY |-> idx_q == 3'd0)
		else $error("footer index nonzero in body mode");
	a_verify_idx_one: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_VERIFY |-> idx_q == 3'd1)
		else $error("footer index off in verify mode");
	a_end_abort_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res.has_result |-> !(res.end_of_frame && res.abort_frame)
			&& !(res.end_of_frame && res.first_of_frame))
		else $error("conflicting frame flags");
	a_len_only_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && !res.end_of_frame |-> res.frame_length == 8'd0)
		else $error("frame length without end of frame");

endmodule

// ===== sv/header_footer_byte_deframer.sv =====
// header_footer_byte_deframer: input register, sync logic and output register
// an accepted byte is held in the input register, and its result is then captured in the output register
// throughput: one byte per cycle; the input stalls only while the output register is held
// header bytes and bytes in hunt produce no item
// reset: hunting the header, pipeline empty, patterns back to "json:" and CR LF
// depends on hfd_pkg, hfd_in_if, hfd_out_if and hfd_sync
module header_footer_byte_deframer (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [hfd_pkg::CFG_W-1:0] cfg_data,
	hfd_in_if.sink                    in_ch,
	hfd_out_if.source                 out_ch
);
	import hfd_pkg::*;

	logic [HDR_W-1:0] header_q;
	logic [FTR_W-1:0] footer_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_q;
	hfd_result_t      res;
	hfd_result_t      res_q;
	logic             out_free;
	logic             step;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HDR_RESET;
			footer_q <= FTR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADER: header_q <= cfg_data[HDR_W-1:0];
				CFG_FOOTER: footer_q <= cfg_data[FTR_W-1:0];
				default:    ;
			endcase
		end
	end

	// handshake: stage 1 moves on whenever the output register can take a result
	assign out_free    = !out_valid_q || out_ch.ready;
	assign step        = valid_s1 && out_free;
	assign in_ch.ready = !valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ch.ready)
			valid_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid)
			byte_s1 <= in_ch.in_byte;
	end

	hfd_sync u_sync (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.byte_s1  (byte_s1),
		.header_q (header_q),
		.footer_q (footer_q),
		.res      (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (step && res.has_result)
			out_valid_q <= 1'b1;
		else if (out_ch.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (step && res.has_result)
			res_q <= res;
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.data_byte      = res_q.data_byte;
	assign out_ch.first_of_frame = res_q.first_of_frame;
	assign out_ch.end_of_frame   = res_q.end_of_frame;
	assign out_ch.abort_frame    = res_q.abort_frame;
	assign out_ch.frame_length   = res_q.frame_length;

endmodule
